// ===== rtl/websocket_frame_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// websocket_frame_receiver_defines.svh
// Assertion macros shared by the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH
`define WEBSOCKET_FRAME_RECEIVER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define WSFR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define WSFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/wsfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfr_pkg
// Types and constants of the frame receiver.
// ----------------------------------------------------------------------------
package wsfr_pkg;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_MASK  = 3'd4,
    PH_DATA  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    EV_DATA  = 2'd0,
    EV_EMPTY = 2'd1,
    EV_ERROR = 2'd2
  } ev_kind_e;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_RSV        = 4'd1,
    ERR_OPCODE     = 4'd2,
    ERR_CTRL_LEN   = 4'd3,
    ERR_CTRL_FRAG  = 4'd4,
    ERR_FRAME_BIG  = 4'd5,
    ERR_STRAY_CONT = 4'd6,
    ERR_NEW_DATA   = 4'd7,
    ERR_MSG_BIG    = 4'd8
  } err_e;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_CLOSE = 4'h8;

  localparam logic [6:0] LEN7_EXT16   = 7'd126;
  localparam logic [6:0] LEN7_EXT64   = 7'd127;
  localparam logic [6:0] CTRL_MAX_LEN = 7'd125;

  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] MASK_LAST  = 3'd3;

  localparam int unsigned LenW = 63;
  localparam int unsigned CfgW = 31;
  localparam int unsigned MsgW = 32;

  localparam logic [CfgW-1:0] CFG_RESET = 31'd2147483646;

  localparam logic REG_MAX_FRAME = 1'b0;
  localparam logic REG_MAX_MSG   = 1'b1;

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] raw;
    logic [7:0] key;
    logic [3:0] frame_op;
    logic [3:0] msg_op;
    logic       frame_end;
    logic       msg_end;
    err_e       code;
  } event_t;

  function automatic logic op_reserved(input logic [3:0] op);
    return (op inside {[4'd3:4'd7]}) || (op >= 4'd11);
  endfunction

endpackage

// ===== rtl/wsfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfr_front
// Header parser and frame/message checker; turns each byte into at most one
// event.
// ----------------------------------------------------------------------------
module wsfr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            byte_i,
  input  logic [30:0]           max_frame_i,
  input  logic [30:0]           max_msg_i,
  output logic                  push_o,
  output wsfr_pkg::event_t      ev_o
);
  import wsfr_pkg::*;

  phase_e          phase_q, phase_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            final_q, final_d;
  logic [3:0]      op_q, op_d;
  logic            mask_q, mask_d;
  logic [31:0]     key_q, key_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [1:0]      midx_q, midx_d;
  logic            skip_q, skip_d;
  logic            frag_q, frag_d;
  logic [3:0]      mkind_q, mkind_d;
  logic [MsgW-1:0] mlen_q, mlen_d;

  logic            ev_valid;
  event_t          ev;
  logic            fin_go;
  logic [LenW-1:0] fin_len;
  logic [LenW-1:0] ext_len;
  logic [6:0]      len7;
  err_e            code;
  logic            control;
  logic            cont;
  logic            frame_big;
  logic            msg_big;
  logic [MsgW:0]   msg_sum;
  logic            last;
  logic            mend;
  logic [2:0]      ext_last;
  logic [31:0]     key_sh;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    final_d  = final_q;
    op_d     = op_q;
    mask_d   = mask_q;
    key_d    = key_q;
    len_d    = len_q;
    rem_d    = rem_q;
    midx_d   = midx_q;
    skip_d   = skip_q;
    frag_d   = frag_q;
    mkind_d  = mkind_q;
    mlen_d   = mlen_q;

    ev_valid    = 1'b0;
    ev.kind     = EV_DATA;
    ev.raw      = byte_i;
    ev.key      = 8'h00;
    ev.frame_op = op_q;
    ev.msg_op   = mkind_q;
    ev.frame_end = 1'b0;
    ev.msg_end  = 1'b0;
    ev.code     = ERR_NONE;

    fin_go   = 1'b0;
    fin_len  = len_q;
    len7     = byte_i[6:0];
    code     = ERR_NONE;
    control  = op_q[3];
    cont     = (op_q == OP_CONT);
    ext_len  = {len_q[LenW-9:0], byte_i};
    ext_last = (phase_q == PH_EXT16) ? EXT16_LAST : EXT64_LAST;
    last     = (rem_q == LenW'(1));
    mend     = 1'b0;
    key_sh   = key_q << {midx_q, 3'b000};

    case (phase_q)
      PH_HDR1: begin
        mask_d = byte_i[7];
        key_d  = '0;
        skip_d = 1'b0;
        if (cnt_q != 3'd0) begin
          code = ERR_RSV;
        end else if (op_reserved(op_q)) begin
          code = ERR_OPCODE;
        end else if (control) begin
          if (len7 > CTRL_MAX_LEN) begin
            code = ERR_CTRL_LEN;
          end else if (!final_q) begin
            code = ERR_CTRL_FRAG;
          end
        end
        if (code != ERR_NONE) begin
          ev_valid = 1'b1;
          ev.kind  = EV_ERROR;
          ev.code  = code;
          frag_d   = 1'b0;
          mkind_d  = OP_CLOSE;
          mlen_d   = '0;
          skip_d   = 1'b1;
        end
        cnt_d = '0;
        len_d = '0;
        if (len7 == LEN7_EXT16) begin
          phase_d = PH_EXT16;
        end else if (len7 == LEN7_EXT64) begin
          phase_d = PH_EXT64;
        end else begin
          len_d   = LenW'(len7);
          fin_len = LenW'(len7);
          if (byte_i[7]) begin
            phase_d = PH_MASK;
          end else begin
            fin_go = 1'b1;
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_d = ext_len;
        if (cnt_q < ext_last) begin
          cnt_d = cnt_q + 3'd1;
        end else begin
          cnt_d = '0;
          if (mask_q) begin
            phase_d = PH_MASK;
          end else begin
            fin_go  = 1'b1;
            fin_len = ext_len;
          end
        end
      end
      PH_MASK: begin
        key_d = {key_q[23:0], byte_i};
        if (cnt_q < MASK_LAST) begin
          cnt_d = cnt_q + 3'd1;
        end else begin
          cnt_d  = '0;
          fin_go = 1'b1;
        end
      end
      PH_DATA: begin
        if (skip_q) begin
          if (last) begin
            skip_d  = 1'b0;
            phase_d = PH_HDR0;
          end else begin
            rem_d = rem_q - LenW'(1);
          end
        end else begin
          mend         = last && !control && final_q;
          ev_valid     = 1'b1;
          ev.kind      = EV_DATA;
          ev.key       = mask_q ? key_sh[31:24] : 8'h00;
          ev.frame_end = last;
          ev.msg_end   = mend;
          if (mend) begin
            frag_d  = 1'b0;
            mkind_d = OP_CLOSE;
            mlen_d  = '0;
          end
          if (last) begin
            phase_d = PH_HDR0;
          end else begin
            rem_d  = rem_q - LenW'(1);
            midx_d = midx_q + 2'd1;
          end
        end
      end
      default: begin
        final_d = byte_i[7];
        cnt_d   = byte_i[6:4];
        op_d    = byte_i[3:0];
        phase_d = PH_HDR1;
      end
    endcase

    frame_big = (fin_len != '0) &&
                ((|fin_len[LenW-1:CfgW]) || (fin_len[CfgW-1:0] > max_frame_i));
    msg_sum   = {1'b0, mlen_q} + {1'b0, fin_len[MsgW-1:0]};
    msg_big   = (|fin_len[LenW-1:MsgW]) || (msg_sum > {2'b00, max_msg_i});

    if (fin_go) begin
      rem_d  = fin_len;
      midx_d = '0;
      if (skip_d) begin
        if (fin_len == '0) begin
          skip_d  = 1'b0;
          phase_d = PH_HDR0;
        end else begin
          phase_d = PH_DATA;
        end
      end else begin
        if (frame_big) begin
          code = ERR_FRAME_BIG;
        end else if (!control) begin
          if (!frag_q && cont) begin
            code = ERR_STRAY_CONT;
          end else if (frag_q && !cont) begin
            code = ERR_NEW_DATA;
          end else begin
            if (!cont) begin
              mkind_d = op_q;
              frag_d  = !final_q;
            end
            if (msg_big) begin
              code = ERR_MSG_BIG;
            end
          end
        end
        ev.msg_op = mkind_d;
        if (code != ERR_NONE) begin
          ev_valid = 1'b1;
          ev.kind  = EV_ERROR;
          ev.code  = code;
          frag_d   = 1'b0;
          mkind_d  = OP_CLOSE;
          mlen_d   = '0;
          if (fin_len == '0) begin
            phase_d = PH_HDR0;
          end else begin
            skip_d  = 1'b1;
            phase_d = PH_DATA;
          end
        end else begin
          if (!control) begin
            mlen_d = mlen_q + fin_len[MsgW-1:0];
          end
          if (fin_len == '0) begin
            mend         = !control && final_q;
            ev_valid     = 1'b1;
            ev.kind      = EV_EMPTY;
            ev.frame_end = 1'b1;
            ev.msg_end   = mend;
            if (mend) begin
              frag_d  = 1'b0;
              mkind_d = OP_CLOSE;
              mlen_d  = '0;
            end
            phase_d = PH_HDR0;
          end else begin
            phase_d = PH_DATA;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      cnt_q   <= '0;
      final_q <= 1'b0;
      op_q    <= '0;
      mask_q  <= 1'b0;
      key_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
      midx_q  <= '0;
      skip_q  <= 1'b0;
      frag_q  <= 1'b0;
      mkind_q <= OP_CLOSE;
      mlen_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      final_q <= final_d;
      op_q    <= op_d;
      mask_q  <= mask_d;
      key_q   <= key_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      midx_q  <= midx_d;
      skip_q  <= skip_d;
      frag_q  <= frag_d;
      mkind_q <= mkind_d;
      mlen_q  <= mlen_d;
    end
  end

  assign push_o = accept_i && ev_valid;
  assign ev_o   = ev;

endmodule

// ===== rtl/wsfr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfr_queue
// Short event queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module wsfr_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wsfr_pkg::event_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output wsfr_pkg::event_t head_o
);
  import wsfr_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  event_t          mem_q [Depth];
  logic [AW-1:0]   wr_q, wr_d;
  logic [AW-1:0]   rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/wsfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfr_back
// Output stage: takes events off the queue, unmasks payload and presents
// the result item.
// ----------------------------------------------------------------------------
module wsfr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  wsfr_pkg::event_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       event_kind_o,
  output logic [7:0]       data_out_o,
  output logic [3:0]       frame_opcode_o,
  output logic [3:0]       message_opcode_o,
  output logic             is_control_o,
  output logic             frame_end_o,
  output logic             message_end_o,
  output logic [3:0]       error_code_o
);
  import wsfr_pkg::*;

  logic   valid_q;
  event_t ev_q;

  assign pop_o = head_valid_i && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ev_q <= head_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign event_kind_o     = ev_q.kind;
  assign data_out_o       = (ev_q.kind == EV_DATA) ? (ev_q.raw ^ ev_q.key) : 8'h00;
  assign frame_opcode_o   = ev_q.frame_op;
  assign message_opcode_o = ev_q.msg_op;
  assign is_control_o     = ev_q.frame_op[3];
  assign frame_end_o      = ev_q.frame_end;
  assign message_end_o    = ev_q.msg_end;
  assign error_code_o     = ev_q.code;

endmodule

// ===== rtl/websocket_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// WebSocket frame receiver: parses headers, unmasks payload, flags errors.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle while in_stall_o is low and returns at
// most one event per byte: an unmasked payload byte, an empty-frame
// completion or an error. The parser decides each byte in the cycle it is
// taken, so a byte may be accepted on every clock while the queue is not
// full. Its event enters a queue of QueueDepth events at that edge and
// moves to the output register once the output register is empty or not
// stalled. in_stall_o is the queue's full flag: with an event on every
// byte and QueueDepth of at least two, the queue holds one event in steady
// flow and fills while out_stall_i is held, and input then stalls until
// the queue is no longer full. Limits are written through the APB port at
// byte address 0 (largest frame payload) and 4 (largest data message
// payload).
// ----------------------------------------------------------------------------
`include "websocket_frame_receiver_defines.svh"

module websocket_frame_receiver #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [7:0]  data_out_o,
  output logic [3:0]  frame_opcode_o,
  output logic [3:0]  message_opcode_o,
  output logic        is_control_o,
  output logic        frame_end_o,
  output logic        message_end_o,
  output logic [3:0]  error_code_o
);
  import wsfr_pkg::*;

  logic [CfgW-1:0] max_frame_q;
  logic [CfgW-1:0] max_msg_q;
  logic            cfg_wr;
  logic            accept;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  event_t          front_ev;
  event_t          q_head;
  logic            out_error;
  logic            error_clean;
  logic            msg_end_clean;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= CFG_RESET;
      max_msg_q   <= CFG_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_FRAME) begin
        max_frame_q <= pwdata[CfgW-1:0];
      end else begin
        max_msg_q <= pwdata[CfgW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MAX_MSG) ? {1'b0, max_msg_q} : {1'b0, max_frame_q};

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  wsfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (byte_in_i),
    .max_frame_i (max_frame_q),
    .max_msg_i   (max_msg_q),
    .push_o      (q_push),
    .ev_o        (front_ev)
  );

  wsfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_ev),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  wsfr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (q_valid),
    .head_i           (q_head),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_kind_o     (event_kind_o),
    .data_out_o       (data_out_o),
    .frame_opcode_o   (frame_opcode_o),
    .message_opcode_o (message_opcode_o),
    .is_control_o     (is_control_o),
    .frame_end_o      (frame_end_o),
    .message_end_o    (message_end_o),
    .error_code_o     (error_code_o)
  );

  assign out_error     = out_valid_o && (event_kind_o == EV_ERROR);
  assign error_clean   = !frame_end_o && !message_end_o && (error_code_o != ERR_NONE) &&
                         (data_out_o == 8'h00);
  assign msg_end_clean = frame_end_o && !is_control_o && (error_code_o == ERR_NONE);

  `WSFR_ASSERT(a_full_implies_out_busy, !q_full || out_valid_o, "queue full with output idle")
  `WSFR_ASSERT_IMP(a_error_fields, out_error, error_clean, "bad error item")
  `WSFR_ASSERT_IMP(a_msg_end_data, out_valid_o && message_end_o, msg_end_clean, "bad message end")

endmodule
